/* rtl/plmb_pkg.sv */
// Shared definitions for the packet loss burst counter.
// Holds field widths, Q1.32 constants, defaults and config register codes.
// No dependencies.
package plmb_pkg;

    // Fixed field widths
    localparam int RAND_W    = 32;
    localparam int PROB_W    = 33;
    localparam int PCOUNT_W  = 32;
    localparam int BURST_W   = 16;
    localparam int CFG_IDX_W = 3;

    // Parameter defaults
    localparam int RUN_BITS_DEF   = 16;
    localparam int COUNT_BITS_DEF = 32;

    // 1.0 in Q1.32
    localparam logic [PROB_W-1:0] ONE_Q32 = {1'b1, {RAND_W{1'b0}}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 3'd0,
        CFG_PROB_0 = 3'd1,
        CFG_PROB_1 = 3'd2,
        CFG_PROB_2 = 3'd3,
        CFG_PROB_3 = 3'd4,
        CFG_PROB_4 = 3'd5,
        CFG_PROB_5 = 3'd6,
        CFG_PCOUNT = 3'd7
    } cfg_idx_t;

    // Model selection
    typedef enum logic {
        MODE_GE     = 1'b0,
        MODE_MARKOV = 1'b1
    } model_mode_t;

    // Chain state codes (GE: S_ONE is good, anything else bad)
    typedef enum logic [1:0] {
        S_ONE   = 2'd0,
        S_TWO   = 2'd1,
        S_THREE = 2'd2,
        S_FOUR  = 2'd3
    } chain_t;

    // Clamp a written probability to 1.0
    function automatic logic [PROB_W-1:0] clamp_prob(input logic [PROB_W-1:0] v);
        clamp_prob = (v > ONE_Q32) ? ONE_Q32 : v;
    endfunction

endpackage

/* rtl/packet_loss_model_burst_counter.sv */
// Packet loss emulator (Gilbert-Elliott / four-state Markov) with signed run counting.
// Depends on plmb_pkg.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  s_      | in        | s_valid / s_ready  | s_rand_a, s_rand_b
//  m_      | out       | m_valid / m_ready  | m_outcome_valid, m_delivered, m_burst_done,
//          |           |                    | m_burst_length, m_last_packet
//  cfg_    | in        | cfg_wr_en          | cfg_index, cfg_wdata
//
// One beat per cycle: each accepted beat is decided in the accept cycle and its
// result appears on m_ in the next cycle from the output register.
// s_ready is high whenever the output register is empty or being drained,
// so a stall on m_ready holds one result and blocks s_ only while it lasts.
// aresetn (synchronous, active low) clears config, chain state, run and count.
module packet_loss_model_burst_counter #(
    parameter int RUN_BITS   = plmb_pkg::RUN_BITS_DEF,
    parameter int COUNT_BITS = plmb_pkg::COUNT_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // config write port
    input  logic                                 cfg_wr_en,
    input  logic [plmb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [plmb_pkg::PROB_W-1:0]          cfg_wdata,
    // input beats
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [plmb_pkg::RAND_W-1:0]          s_rand_a,
    input  logic [plmb_pkg::RAND_W-1:0]          s_rand_b,
    // result beats
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_outcome_valid,
    output logic                                 m_delivered,
    output logic                                 m_burst_done,
    output logic signed [plmb_pkg::BURST_W-1:0]  m_burst_length,
    output logic                                 m_last_packet
);
    import plmb_pkg::*;

    localparam logic signed [RUN_BITS-1:0] RUN_MAX = {1'b0, {(RUN_BITS-1){1'b1}}};
    localparam logic signed [RUN_BITS-1:0] RUN_MIN = -RUN_MAX;
    localparam logic signed [RUN_BITS-1:0] RUN_POS1 = RUN_BITS'(1);
    localparam logic signed [RUN_BITS-1:0] RUN_NEG1 = -RUN_POS1;
    localparam logic [PCOUNT_W-1:0] COUNT_MAX = PCOUNT_W'({COUNT_BITS{1'b1}});

    // config registers
    model_mode_t              mode_reg;
    logic [PROB_W-1:0]        prob_reg [6];
    logic [PCOUNT_W-1:0]      pcount_reg;

    // model state
    chain_t                   chain_reg, chain_next;
    logic                     warm_reg;
    logic signed [RUN_BITS-1:0] run_reg, run_next;
    logic [COUNT_BITS-1:0]    done_reg, done_next;

    // output register
    logic                     m_valid_reg;
    logic                     ov_reg, dlv_reg, bdone_reg, last_reg;
    logic signed [BURST_W-1:0] blen_reg;
    logic                     ov_next, dlv_next, bdone_next, last_next;
    logic signed [BURST_W-1:0] blen_next;

    logic                     s_acc;
    logic [PCOUNT_W-1:0]      limit;
    logic [PCOUNT_W-1:0]      done_ext;
    logic                     active;
    logic                     send;
    chain_t                   chain_mv;
    logic [PROB_W:0]          ge_sum;
    logic [PROB_W:0]          mk_sum14, mk_sum21;
    logic [PROB_W:0]          a_ext, b_ext;
    logic signed [31:0]       run_ext;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_acc   = s_valid && s_ready;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_GE;
            pcount_reg <= '0;
            for (int i = 0; i < 6; i++) begin
                prob_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MODE:   mode_reg    <= model_mode_t'(cfg_wdata[0]);
                CFG_PROB_0: prob_reg[0] <= clamp_prob(cfg_wdata);
                CFG_PROB_1: prob_reg[1] <= clamp_prob(cfg_wdata);
                CFG_PROB_2: prob_reg[2] <= clamp_prob(cfg_wdata);
                CFG_PROB_3: prob_reg[3] <= clamp_prob(cfg_wdata);
                CFG_PROB_4: prob_reg[4] <= clamp_prob(cfg_wdata);
                CFG_PROB_5: prob_reg[5] <= clamp_prob(cfg_wdata);
                CFG_PCOUNT: pcount_reg  <= cfg_wdata[PCOUNT_W-1:0];
                default:    ;
            endcase
        end
    end

    // chain step: delivery decision and next state
    assign a_ext    = {2'b00, s_rand_a};
    assign b_ext    = {2'b00, s_rand_b};
    assign mk_sum14 = {1'b0, prob_reg[0]} + {1'b0, prob_reg[4]};
    assign mk_sum21 = {1'b0, prob_reg[2]} + {1'b0, prob_reg[1]};

    always_comb begin
        ge_sum   = '0;
        send     = 1'b0;
        chain_mv = chain_reg;
        if (mode_reg == MODE_GE) begin
            if (chain_reg == S_ONE) begin
                ge_sum   = a_ext + {1'b0, prob_reg[2]};
                chain_mv = (b_ext <= {1'b0, prob_reg[0]}) ? S_TWO : S_ONE;
            end else begin
                ge_sum   = a_ext + {1'b0, prob_reg[3]};
                chain_mv = (b_ext <= {1'b0, prob_reg[1]}) ? S_ONE : S_TWO;
            end
            // a > 1.0 - x  <=>  a + x > 1.0
            send = (ge_sum > {1'b0, ONE_Q32});
        end else begin
            unique case (chain_reg)
                S_ONE: begin
                    send = 1'b1;
                    if (a_ext <= {1'b0, prob_reg[0]}) begin
                        chain_mv = S_THREE;
                    end else if (a_ext <= mk_sum14) begin
                        chain_mv = S_FOUR;
                    end
                end
                S_TWO: begin
                    send = 1'b1;
                    if (a_ext <= {1'b0, prob_reg[3]}) begin
                        chain_mv = S_THREE;
                    end
                end
                S_THREE: begin
                    send = 1'b0;
                    if (a_ext <= {1'b0, prob_reg[2]}) begin
                        chain_mv = S_TWO;
                    end else if (a_ext <= mk_sum21) begin
                        chain_mv = S_ONE;
                    end
                end
                S_FOUR: begin
                    send = 1'b0;
                    if (a_ext <= {1'b0, prob_reg[5]}) begin
                        chain_mv = S_ONE;
                    end
                end
                default: ;
            endcase
        end
    end

    // outcome limit and run bookkeeping
    assign limit    = (pcount_reg > COUNT_MAX) ? COUNT_MAX : pcount_reg;
    assign done_ext = PCOUNT_W'(done_reg);
    assign active   = warm_reg && (done_ext < limit);
    assign run_ext  = 32'(run_reg);

    always_comb begin
        chain_next = chain_reg;
        run_next   = run_reg;
        done_next  = done_reg;
        ov_next    = 1'b0;
        dlv_next   = 1'b0;
        bdone_next = 1'b0;
        blen_next  = '0;
        last_next  = 1'b0;
        if (!warm_reg) begin
            chain_next = chain_mv;
        end else if (active) begin
            chain_next = chain_mv;
            ov_next    = 1'b1;
            dlv_next   = send;
            if (run_reg == '0) begin
                run_next = send ? RUN_POS1 : RUN_NEG1;
            end else if ((run_reg > 0) == send) begin
                if (send && run_reg < RUN_MAX) begin
                    run_next = run_reg + RUN_POS1;
                end else if (!send && run_reg > RUN_MIN) begin
                    run_next = run_reg - RUN_POS1;
                end
            end else begin
                bdone_next = 1'b1;
                blen_next  = run_ext[BURST_W-1:0];
                run_next   = send ? RUN_POS1 : RUN_NEG1;
            end
            done_next = done_reg + COUNT_BITS'(1);
            last_next = ((done_ext + PCOUNT_W'(1)) == limit);
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg <= S_ONE;
            warm_reg  <= 1'b0;
            run_reg   <= '0;
            done_reg  <= '0;
        end else if (s_acc) begin
            chain_reg <= chain_next;
            warm_reg  <= 1'b1;
            run_reg   <= run_next;
            done_reg  <= done_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_acc) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            ov_reg    <= ov_next;
            dlv_reg   <= dlv_next;
            bdone_reg <= bdone_next;
            blen_reg  <= blen_next;
            last_reg  <= last_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_outcome_valid = ov_reg;
    assign m_delivered     = dlv_reg;
    assign m_burst_done    = bdone_reg;
    assign m_burst_length  = blen_reg;
    assign m_last_packet   = last_reg;

    // checks
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result register not empty after reset");

    a_burst_has_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_burst_done |-> m_outcome_valid)
        else $error("run reported without a packet outcome");

    a_last_has_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_packet |-> m_outcome_valid)
        else $error("last packet flagged without a packet outcome");

    a_run_open: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && active |=> run_reg != '0)
        else $error("run length zero after a packet outcome");

    a_held_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(run_reg) && $stable(chain_reg))
        else $error("state moved while a result was stalled");

endmodule

/* verif/packet_loss_model_burst_counter_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for packet_loss_model_burst_counter: directed table, long runs,
// then random config phases, every result beat checked against a behavioral loss model or a typed row.
// Depends on plmb_pkg and the packet_loss_model_burst_counter RTL.
module packet_loss_model_burst_counter_test;
    import plmb_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 12;
    localparam int MAX_IDLE        = 11;
    localparam int HOLD_CYCLES     = 300;
    localparam int ITEM_TARGET     = 1150;
    localparam int STREAK_LEN      = 40;
    localparam int RUN_SAT         = (1 << (RUN_BITS_DEF - 1)) - 1;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int SHOWN_MAX       = 10;
    localparam logic [33:0] ONE_WIDE = {1'b0, ONE_Q32};

    // One result beat as seen on m_
    typedef struct packed {
        logic                       ov;
        logic                       dlv;
        logic                       bd;
        logic signed [BURST_W-1:0]  blen;
        logic                       last;
    } outcome_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_BEAT,
        ROW_TYPED
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        cfg_idx_t           idx;
        logic [PROB_W-1:0]  data;
        logic [RAND_W-1:0]  a;
        logic [RAND_W-1:0]  b;
        outcome_t           res;
    } plan_row_t;

    localparam outcome_t NO_OUTCOME = '0;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [PROB_W-1:0]          cfg_wdata = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [RAND_W-1:0]          s_rand_a = '0;
    logic [RAND_W-1:0]          s_rand_b = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic                       m_outcome_valid;
    logic                       m_delivered;
    logic                       m_burst_done;
    logic signed [BURST_W-1:0]  m_burst_length;
    logic                       m_last_packet;

    packet_loss_model_burst_counter dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rand_a        (s_rand_a),
        .s_rand_b        (s_rand_b),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_outcome_valid (m_outcome_valid),
        .m_delivered     (m_delivered),
        .m_burst_done    (m_burst_done),
        .m_burst_length  (m_burst_length),
        .m_last_packet   (m_last_packet)
    );

    // Loss model state and its copy of the registers
    model_mode_t        mode_q = MODE_GE;
    logic [PROB_W-1:0]  prob_q [6];
    logic [31:0]        pcount_q = '0;
    chain_t             chain_q = S_ONE;
    bit                 warm_q = 1'b0;
    int                 run_q = 0;
    logic [31:0]        done_q = '0;
    int                 items_sent = 0;

    plan_row_t          plan_rows [$];
    outcome_t           pending_outcomes [$];
    int                 bad_beats = 0;
    int                 cycle_count = 0;
    bit                 idle_on = 1'b1;
    bit                 hold_pending = 1'b0;

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // Move the chain one step; returns 1 when the packet gets through
    function automatic logic step_chain(logic [RAND_W-1:0] a, logic [RAND_W-1:0] b);
        logic [33:0] aw;
        logic [33:0] bw;
        logic [33:0] sum_one;
        logic [33:0] sum_three;
        logic        send;
        aw = {2'b00, a};
        bw = {2'b00, b};
        sum_one = {1'b0, prob_q[0]} + {1'b0, prob_q[4]};
        sum_three = {1'b0, prob_q[2]} + {1'b0, prob_q[1]};
        send = 1'b0;
        if (mode_q == MODE_GE) begin
            // any non-zero code counts as the bad state
            if (chain_q == S_ONE) begin
                send = aw > (ONE_WIDE - {1'b0, prob_q[2]});
                chain_q = (bw <= {1'b0, prob_q[0]}) ? S_TWO : S_ONE;
            end else begin
                send = aw > (ONE_WIDE - {1'b0, prob_q[3]});
                chain_q = (bw <= {1'b0, prob_q[1]}) ? S_ONE : S_TWO;
            end
        end else begin
            case (chain_q)
                S_ONE: begin
                    send = 1'b1;
                    if (aw <= {1'b0, prob_q[0]}) chain_q = S_THREE;
                    else if (aw <= sum_one) chain_q = S_FOUR;
                end
                S_TWO: begin
                    send = 1'b1;
                    if (aw <= {1'b0, prob_q[3]}) chain_q = S_THREE;
                end
                S_THREE: begin
                    send = 1'b0;
                    if (aw <= {1'b0, prob_q[2]}) chain_q = S_TWO;
                    else if (aw <= sum_three) chain_q = S_ONE;
                end
                default: begin
                    send = 1'b0;
                    if (aw <= {1'b0, prob_q[5]}) chain_q = S_ONE;
                end
            endcase
        end
        return send;
    endfunction

    // Expected result beat for one accepted input beat
    function automatic outcome_t next_outcome(logic [RAND_W-1:0] a, logic [RAND_W-1:0] b);
        outcome_t r;
        logic     send;
        r = NO_OUTCOME;
        if (!warm_q) begin
            void'(step_chain(a, b));
            warm_q = 1'b1;
            return r;
        end
        if (done_q >= pcount_q) return r;
        send = step_chain(a, b);
        r.ov = 1'b1;
        r.dlv = send;
        if (run_q == 0) begin
            run_q = send ? 1 : -1;
        end else if ((run_q > 0) == send) begin
            if (send) begin
                if (run_q < RUN_SAT) run_q++;
            end else begin
                if (run_q > -RUN_SAT) run_q--;
            end
        end else begin
            r.bd = 1'b1;
            r.blen = run_q[BURST_W-1:0];
            run_q = send ? 1 : -1;
        end
        done_q++;
        r.last = (done_q == pcount_q);
        return r;
    endfunction

    function automatic plan_row_t cfg_row(cfg_idx_t idx, logic [PROB_W-1:0] data);
        plan_row_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.idx = idx;
        row.data = data;
        return row;
    endfunction

    function automatic plan_row_t beat_row(logic [RAND_W-1:0] a, logic [RAND_W-1:0] b);
        plan_row_t row;
        row = '0;
        row.kind = ROW_BEAT;
        row.a = a;
        row.b = b;
        return row;
    endfunction

    function automatic plan_row_t typed_row(logic [RAND_W-1:0] a, logic [RAND_W-1:0] b,
                                            outcome_t res);
        plan_row_t row;
        row = beat_row(a, b);
        row.kind = ROW_TYPED;
        row.res = res;
        return row;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(plan_row_t row);
        plan_rows.insert(plan_rows.size(), row);
    endfunction

    // Probabilities lean on zero, one, above one and the values next to them
    function automatic logic [PROB_W-1:0] rand_prob();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ONE_Q32;
            2: return {1'b1, 32'($urandom)};
            3: return PROB_W'($urandom_range(1, 255));
            4: return ONE_Q32 - PROB_W'($urandom_range(1, 255));
            default: return {1'b0, 32'($urandom)};
        endcase
    endfunction

    // Draws hit the extremes and both sides of the current thresholds
    function automatic logic [RAND_W-1:0] rand_draw();
        logic [33:0] marks [6];
        logic [33:0] t;
        marks[0] = ONE_WIDE - {1'b0, prob_q[2]};
        marks[1] = ONE_WIDE - {1'b0, prob_q[3]};
        marks[2] = {1'b0, prob_q[0]} + {1'b0, prob_q[4]};
        marks[3] = {1'b0, prob_q[2]} + {1'b0, prob_q[1]};
        marks[4] = {1'b0, prob_q[$urandom_range(0, 5)]};
        marks[5] = {1'b0, prob_q[$urandom_range(0, 5)]};
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3: begin
                t = marks[$urandom_range(0, 5)] + 34'($urandom_range(0, 2)) - 34'd1;
                return t[RAND_W-1:0];
            end
            default: return $urandom;
        endcase
    endfunction

    // Register write; the model copy follows once the DUT has clocked the write in
    task automatic write_reg(cfg_idx_t idx, logic [PROB_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_MODE:   mode_q = model_mode_t'(data[0]);
            CFG_PCOUNT: pcount_q = data[31:0];
            default:    prob_q[int'(idx) - 1] = (data > ONE_Q32) ? ONE_Q32 : data;
        endcase
    endtask

    // Offer one input beat; the expectation is queued at the accepting edge
    task automatic send_beat(logic [RAND_W-1:0] a, logic [RAND_W-1:0] b, bit typed,
                             outcome_t typed_res);
        int       gap;
        outcome_t predicted;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_rand_a <= a;
        s_rand_b <= b;
        do @(posedge aclk); while (!s_ready);
        predicted = next_outcome(a, b);
        pending_outcomes.insert(pending_outcomes.size(), typed ? typed_res : predicted);
        items_sent++;
    endtask

    // Stop offering and wait until every queued result has come back
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(negedge aclk);
    endtask

    // Result side: random stalls, one long hold-off on request, in-order check
    initial begin
        int       stall;
        outcome_t got;
        outcome_t want;
        wait (aresetn);
        forever begin
            stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (hold_pending) begin
                hold_pending = 1'b0;
                stall = HOLD_CYCLES;
            end
            repeat (stall) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.ov = m_outcome_valid;
            got.dlv = m_delivered;
            got.bd = m_burst_done;
            got.blen = m_burst_length;
            got.last = m_last_packet;
            if (pending_outcomes.size() == 0) begin
                bad_beats++;
                if (bad_beats <= SHOWN_MAX)
                    $display("unexpected result beat at cycle %0d", cycle_count);
            end else begin
                want = pending_outcomes.pop_front();
                if (got !== want) begin
                    bad_beats++;
                    if (bad_beats <= SHOWN_MAX)
                        $display({"cycle %0d mismatch: exp ov=%b dlv=%b bd=%b len=%0d last=%b",
                                  " got ov=%b dlv=%b bd=%b len=%0d last=%b"},
                                 cycle_count, want.ov, want.dlv, want.bd, want.blen,
                                 want.last, got.ov, got.dlv, got.bd, got.blen, got.last);
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[packet_loss_model_burst_counter] ERROR");
        $finish;
    end

    initial begin
        int          phase_no;
        int          phase_len;
        logic [32:0] count_val;

        foreach (prob_q[i]) prob_q[i] = '0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table. Warm-up beat with all registers at reset, then a zero packet count.
        add_row(typed_row(32'h0, 32'h0, NO_OUTCOME));
        add_row(typed_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, NO_OUTCOME));
        // GE with k at one, h at zero, p above one (clamps), r at zero
        add_row(cfg_row(CFG_PCOUNT, 33'h0_FFFF_FFFF));
        add_row(cfg_row(CFG_PROB_0, 33'h1_FFFF_FFFF));
        add_row(cfg_row(CFG_PROB_1, 33'h0));
        add_row(cfg_row(CFG_PROB_2, ONE_Q32));
        add_row(cfg_row(CFG_PROB_3, 33'h0));
        // warm-up left the chain bad; h at zero loses the first packet
        add_row(typed_row(32'h0, 32'h0, outcome_t'({1'b1, 1'b0, 1'b0, 16'sd0, 1'b0})));
        add_row(beat_row(32'h0, 32'hFFFF_FFFF));
        add_row(beat_row(32'hFFFF_FFFF, 32'h0));
        add_row(beat_row(32'h1, 32'h1));
        add_row(beat_row(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        add_row(beat_row(32'h8000_0000, 32'h0));
        // Markov chain, draws on and beside each threshold
        add_row(cfg_row(CFG_MODE, 33'(MODE_MARKOV)));
        add_row(cfg_row(CFG_PROB_0, 33'h0_4000_0000));
        add_row(cfg_row(CFG_PROB_4, 33'h0_4000_0000));
        add_row(cfg_row(CFG_PROB_1, 33'h0_8000_0000));
        add_row(cfg_row(CFG_PROB_2, 33'h0_4000_0000));
        add_row(cfg_row(CFG_PROB_3, 33'h0_8000_0000));
        add_row(cfg_row(CFG_PROB_5, 33'h0_8000_0000));
        add_row(beat_row(32'h4000_0000, 32'h0));
        add_row(beat_row(32'h0000_0000, 32'h0));
        add_row(beat_row(32'h8000_0001, 32'h0));
        add_row(beat_row(32'h8000_0000, 32'h0));
        add_row(beat_row(32'h8000_0000, 32'h0));
        add_row(beat_row(32'h4000_0001, 32'h0));
        add_row(beat_row(32'hFFFF_FFFF, 32'h0));
        add_row(beat_row(32'h8000_0000, 32'h0));
        // 14 outcomes so far: the count ends two beats later, then beats are ignored
        add_row(cfg_row(CFG_PCOUNT, 33'd16));
        add_row(beat_row(32'hFFFF_FFFF, 32'h0));
        add_row(beat_row(32'h0, 32'h0));
        add_row(typed_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, NO_OUTCOME));

        foreach (plan_rows[i]) begin
            case (plan_rows[i].kind)
                ROW_CFG: begin
                    drain();
                    write_reg(plan_rows[i].idx, plan_rows[i].data);
                end
                ROW_BEAT:  send_beat(plan_rows[i].a, plan_rows[i].b, 1'b0, NO_OUTCOME);
                default:   send_beat(plan_rows[i].a, plan_rows[i].b, 1'b1, plan_rows[i].res);
            endcase
        end

        // Long runs: a delivered run, then a lost run, back to back
        drain();
        idle_on = 1'b0;
        write_reg(CFG_MODE, 33'(MODE_GE));
        write_reg(CFG_PROB_0, 33'h0);
        write_reg(CFG_PROB_1, ONE_Q32);
        write_reg(CFG_PROB_2, ONE_Q32);
        write_reg(CFG_PROB_3, 33'h0);
        write_reg(CFG_PCOUNT, 33'h0_FFFF_FFFF);
        repeat (STREAK_LEN) send_beat($urandom | 32'h1, $urandom | 32'h1, 1'b0, NO_OUTCOME);
        // a zero draw in the good state is lost and closes the delivered run
        send_beat(32'h0, 32'h1, 1'b0, NO_OUTCOME);
        drain();
        write_reg(CFG_PROB_2, 33'h0);
        repeat (STREAK_LEN) send_beat($urandom, $urandom | 32'h1, 1'b0, NO_OUTCOME);
        drain();
        write_reg(CFG_PROB_2, ONE_Q32);
        send_beat(32'h1, 32'h1, 1'b0, NO_OUTCOME);

        // Random phases: fresh registers each time, mode switches keep the chain
        phase_no = 0;
        while (items_sent < ITEM_TARGET) begin
            phase_no++;
            drain();
            idle_on = ($urandom_range(0, 4) != 0);
            write_reg(CFG_MODE, 33'($urandom_range(0, 1)));
            for (int i = 1; i <= 6; i++) write_reg(cfg_idx_t'(i), rand_prob());
            phase_len = $urandom_range(40, 120);
            case ($urandom_range(0, 7))
                0: count_val = 33'h0_FFFF_FFFF;
                1: begin
                    // count already reached: beats pass without moving the chain
                    count_val = {1'b0, done_q};
                    phase_len = $urandom_range(3, 8);
                end
                default: count_val = 33'(done_q) + 33'($urandom_range(phase_len / 2,
                                                                      phase_len + 20));
            endcase
            write_reg(CFG_PCOUNT, count_val);
            hold_pending = (phase_no % 5 == 2);
            repeat (phase_len) send_beat(rand_draw(), rand_draw(), 1'b0, NO_OUTCOME);
        end

        drain();
        repeat (4) @(posedge aclk);
        if (pending_outcomes.size() != 0) begin
            bad_beats += pending_outcomes.size();
            $display("%0d result beats never arrived", pending_outcomes.size());
        end
        if (bad_beats == 0)
            $display("[packet_loss_model_burst_counter] OK");
        else
            $display("[packet_loss_model_burst_counter] ERROR");
        $finish;
    end

endmodule

/* sim.f */
rtl/plmb_pkg.sv
rtl/packet_loss_model_burst_counter.sv
verif/packet_loss_model_burst_counter_test.sv
